/* hdl/dtdpw_pkg.sv */
package dtdpw_pkg;

   // Field widths that do not follow from the coordinate width.
   localparam int DEPTH_BITS     = 16;
   localparam int DEPTH_MAG_BITS = DEPTH_BITS - 1;
   localparam int CHAN_BITS      = 8;
   localparam int FOCAL_BITS     = 12;
   localparam int BASE_BITS      = 10;
   localparam int PROD_BITS      = FOCAL_BITS + BASE_BITS;

   // Register reset values.
   localparam logic [FOCAL_BITS-1:0] FOCAL_RESET = FOCAL_BITS'(604);
   localparam logic [BASE_BITS-1:0]  BASE_RESET  = BASE_BITS'(50);

   // Register port geometry: two 32-bit registers at byte offsets 0 and 4.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Quotient bits resolved by each divider stage.
   localparam int DIV_STEP = 3;

   // Register index, taken from the word address.
   typedef enum logic [0:0] {
      REG_FOCAL_LENGTH    = 1'b0,
      REG_STEREO_BASELINE = 1'b1
   } reg_index_type;

endpackage

/* hdl/dtdpw_div.sv */
module dtdpw_div
   import dtdpw_pkg::*;
#(
   parameter int QUO_BITS      = 12,
   parameter int DIVIDEND_BITS = 22,
   parameter int DIVISOR_BITS  = 15,
   parameter int SIDE_BITS     = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [DIVIDEND_BITS-1:0] in_dividend,
   input  logic [DIVISOR_BITS-1:0]  in_divisor,
   input  logic [SIDE_BITS-1:0]     in_side,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [QUO_BITS-1:0]      out_quotient,
   output logic [SIDE_BITS-1:0]     out_side
);

   // The caller guarantees dividend < divisor << QUO_BITS, so QUO_BITS
   // quotient bits hold the full result.
   localparam int NUM_STAGES = (QUO_BITS + DIV_STEP - 1) / DIV_STEP;
   localparam int SHIFT_BITS = DIVISOR_BITS + QUO_BITS;
   localparam int WIDE_BITS  = (SHIFT_BITS > DIVIDEND_BITS) ? SHIFT_BITS : DIVIDEND_BITS;

   logic [DIVIDEND_BITS-1:0] rem_ff  [NUM_STAGES];
   logic [QUO_BITS-1:0]      quo_ff  [NUM_STAGES];
   logic [DIVISOR_BITS-1:0]  div_ff  [NUM_STAGES];
   logic [SIDE_BITS-1:0]     side_ff [NUM_STAGES];
   logic [NUM_STAGES-1:0]    vld_ff;

   // Stage inputs: index 0 is the port, index s+1 is the register of stage s.
   logic [DIVIDEND_BITS-1:0] stg_rem  [NUM_STAGES+1];
   logic [QUO_BITS-1:0]      stg_quo  [NUM_STAGES+1];
   logic [DIVISOR_BITS-1:0]  stg_div  [NUM_STAGES+1];
   logic [SIDE_BITS-1:0]     stg_side [NUM_STAGES+1];
   logic [NUM_STAGES:0]      stg_vld;
   logic [NUM_STAGES:0]      rdy;

   assign stg_rem[0]  = in_dividend;
   assign stg_quo[0]  = '0;
   assign stg_div[0]  = in_divisor;
   assign stg_side[0] = in_side;
   assign stg_vld[0]  = in_valid;

   assign rdy[NUM_STAGES] = out_ready;
   assign in_ready        = rdy[0];

   assign out_valid    = stg_vld[NUM_STAGES];
   assign out_quotient = stg_quo[NUM_STAGES];
   assign out_side     = stg_side[NUM_STAGES];

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      localparam int BIT_HI = QUO_BITS - 1 - s * DIV_STEP;
      localparam int STEPS  = (BIT_HI + 1 < DIV_STEP) ? BIT_HI + 1 : DIV_STEP;

      logic [DIVIDEND_BITS-1:0] rem_in;
      logic [QUO_BITS-1:0]      quo_in;
      logic [WIDE_BITS-1:0]     rem_wide;
      logic [WIDE_BITS-1:0]     trial;

      // Restoring division: try the shifted divisor for each quotient bit
      // of this stage, most significant first.
      always_comb begin
         rem_wide = WIDE_BITS'(stg_rem[s]);
         quo_in   = stg_quo[s];
         trial    = '0;
         for (int j = 0; j < STEPS; j++) begin
            trial = WIDE_BITS'(stg_div[s]) << (BIT_HI - j);
            if (rem_wide >= trial) begin
               rem_wide           = rem_wide - trial;
               quo_in[BIT_HI - j] = 1'b1;
            end
         end
         rem_in = DIVIDEND_BITS'(rem_wide);
      end

      // A stage takes a new beat when it is empty or its beat moves on.
      assign rdy[s] = !vld_ff[s] || rdy[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= stg_vld[s];
         end
         if (rdy[s]) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            div_ff[s]  <= stg_div[s];
            side_ff[s] <= stg_side[s];
         end
      end

      assign stg_rem[s+1]  = rem_ff[s];
      assign stg_quo[s+1]  = quo_ff[s];
      assign stg_div[s+1]  = div_ff[s];
      assign stg_side[s+1] = side_ff[s];
      assign stg_vld[s+1]  = vld_ff[s];
   end

`ifndef NO_ASSERTIONS
   // A finished division leaves a remainder below the divisor.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NUM_STAGES-1] |->
         (WIDE_BITS'(rem_ff[NUM_STAGES-1]) < WIDE_BITS'(div_ff[NUM_STAGES-1])))
      else $error("divider remainder not below divisor");

   // The input is held off only while the first stage holds a beat.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> vld_ff[0])
      else $error("divider refused a beat with an empty first stage");

   // A beat held at the output by back-pressure stays there.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_quotient)))
      else $error("divider output changed while held");
`endif

endmodule

/* hdl/depth_to_disparity_pixel_warp_top.sv */
// Forward warp of one left-image pixel into the right view. Each beat carries a pixel's row,
// column, signed depth and three color channels; the block computes the disparity
// floor(focal_length * stereo_baseline / depth) and, when the depth is positive and the
// column minus the disparity is above zero, emits one beat with the same row, the shifted
// column and the colors; otherwise the pixel produces no result beat. The block takes one
// pixel every clock while req_stall is low and holds no state between pixels. It is made of an
// input stage that also screens out non-positive depths and disparities of 2^COORD_BITS or
// more, a pipelined restoring divider that settles three quotient bits per stage, and an
// output register. Focal length (offset 0) and baseline (offset 4) are to be written through
// the register port while no pixel is in flight; the block itself does not enforce this.
module depth_to_disparity_pixel_warp_top
   import dtdpw_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   // Register port.
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                      csr_pready,
   // Pixel input.
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [COORD_BITS-1:0]     req_pixel_row,
   input  logic [COORD_BITS-1:0]     req_pixel_col,
   input  logic signed [DEPTH_BITS-1:0] req_pixel_depth,
   input  logic [CHAN_BITS-1:0]      req_chan0,
   input  logic [CHAN_BITS-1:0]      req_chan1,
   input  logic [CHAN_BITS-1:0]      req_chan2,
   // Warped pixel output.
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [COORD_BITS-1:0]     rsp_dest_row,
   output logic [COORD_BITS-1:0]     rsp_dest_col,
   output logic [CHAN_BITS-1:0]      rsp_out_chan0,
   output logic [CHAN_BITS-1:0]      rsp_out_chan1,
   output logic [CHAN_BITS-1:0]      rsp_out_chan2
);

   localparam int DIV_W     = DEPTH_MAG_BITS + COORD_BITS;
   localparam int SIDE_BITS = 2 * COORD_BITS + 3 * CHAN_BITS;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [FOCAL_BITS-1:0] focal_ff;
   logic [BASE_BITS-1:0]  base_ff;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [FOCAL_BITS-1:0] focal_in;
   logic [BASE_BITS-1:0]  base_in;
   logic                  cfg_wr;
   reg_index_type         cfg_index;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_index  = reg_index_type'(csr_paddr[2]);

   // Next register values: a write replaces one of them.
   always_comb begin
      focal_in = focal_ff;
      base_in  = base_ff;
      if (cfg_wr) begin
         unique case (cfg_index)
            REG_FOCAL_LENGTH:    focal_in = csr_pwdata[FOCAL_BITS-1:0];
            REG_STEREO_BASELINE: base_in  = csr_pwdata[BASE_BITS-1:0];
         endcase
      end
   end

   // The disparity numerator is updated together with the registers, so a pixel
   // taken right after a write already sees the new product.
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= FOCAL_RESET;
         base_ff  <= BASE_RESET;
         prod_ff  <= PROD_BITS'(FOCAL_RESET) * PROD_BITS'(BASE_RESET);
      end else begin
         focal_ff <= focal_in;
         base_ff  <= base_in;
         prod_ff  <= PROD_BITS'(focal_in) * PROD_BITS'(base_in);
      end
   end

   // Read back.
   always_comb begin
      unique case (cfg_index)
         REG_FOCAL_LENGTH:    csr_prdata = CSR_DATA_BITS'(focal_ff);
         REG_STEREO_BASELINE: csr_prdata = CSR_DATA_BITS'(base_ff);
      endcase
   end

   // ------------------------------------------------------------------
   // Input stage: screen the depth and register the beat.
   // ------------------------------------------------------------------
   logic                      a_vld_ff;
   logic [COORD_BITS-1:0]     a_row_ff;
   logic [COORD_BITS-1:0]     a_col_ff;
   logic [DEPTH_MAG_BITS-1:0] a_depth_ff;
   logic [CHAN_BITS-1:0]      a_chan0_ff;
   logic [CHAN_BITS-1:0]      a_chan1_ff;
   logic [CHAN_BITS-1:0]      a_chan2_ff;
   logic                      a_ready;
   logic                      depth_ok;
   logic                      disp_too_big;
   logic                      div_in_ready;

   assign depth_ok = !req_pixel_depth[DEPTH_BITS-1] && (req_pixel_depth != '0);

   // A disparity of 2^COORD_BITS or more never leaves a column above zero.
   assign disp_too_big = DIV_W'(prod_ff) >=
                         (DIV_W'(req_pixel_depth[DEPTH_MAG_BITS-1:0]) << COORD_BITS);

   assign a_ready   = !a_vld_ff || div_in_ready;
   assign req_stall = !a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (a_ready) begin
         a_vld_ff <= req_valid && depth_ok && !disp_too_big;
      end
      if (a_ready) begin
         a_row_ff   <= req_pixel_row;
         a_col_ff   <= req_pixel_col;
         a_depth_ff <= req_pixel_depth[DEPTH_MAG_BITS-1:0];
         a_chan0_ff <= req_chan0;
         a_chan1_ff <= req_chan1;
         a_chan2_ff <= req_chan2;
      end
   end

   // ------------------------------------------------------------------
   // Disparity divider, with the pixel riding alongside.
   // ------------------------------------------------------------------
   logic                  div_out_valid;
   logic                  div_out_ready;
   logic [COORD_BITS-1:0] disparity;
   logic [SIDE_BITS-1:0]  div_out_side;
   logic [COORD_BITS-1:0] d_row;
   logic [COORD_BITS-1:0] d_col;
   logic [CHAN_BITS-1:0]  d_chan0;
   logic [CHAN_BITS-1:0]  d_chan1;
   logic [CHAN_BITS-1:0]  d_chan2;

   dtdpw_div #(
      .QUO_BITS      (COORD_BITS),
      .DIVIDEND_BITS (PROD_BITS),
      .DIVISOR_BITS  (DEPTH_MAG_BITS),
      .SIDE_BITS     (SIDE_BITS)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (a_vld_ff),
      .in_ready     (div_in_ready),
      .in_dividend  (prod_ff),
      .in_divisor   (a_depth_ff),
      .in_side      ({a_row_ff, a_col_ff, a_chan2_ff, a_chan1_ff, a_chan0_ff}),
      .out_valid    (div_out_valid),
      .out_ready    (div_out_ready),
      .out_quotient (disparity),
      .out_side     (div_out_side)
   );

   assign {d_row, d_col, d_chan2, d_chan1, d_chan0} = div_out_side;

   // ------------------------------------------------------------------
   // Output register: keep only targets right of column zero.
   // ------------------------------------------------------------------
   logic rsp_valid_ff;

   assign div_out_ready = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_out_ready) begin
         rsp_valid_ff <= div_out_valid && (disparity < d_col);
      end
      if (div_out_ready) begin
         rsp_dest_row  <= d_row;
         rsp_dest_col  <= d_col - disparity;
         rsp_out_chan0 <= d_chan0;
         rsp_out_chan1 <= d_chan1;
         rsp_out_chan2 <= d_chan2;
      end
   end

`ifndef NO_ASSERTIONS
   // Column zero is never a target.
   a_no_col_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dest_col != '0))
      else $error("result beat targets column zero");

   // A beat without a positive depth never enters the pipeline.
   a_bad_depth_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !depth_ok) |=> !a_vld_ff)
      else $error("beat with non-positive depth entered the pipeline");

   // The input is held off only while the input stage holds a beat.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> a_vld_ff)
      else $error("input stalled with an empty input stage");

   // The disparity numerator tracks the registers.
   a_prod_tracks_cfg: assert property (@(posedge clock) disable iff (reset)
      prod_ff == PROD_BITS'(focal_ff) * PROD_BITS'(base_ff))
      else $error("disparity numerator out of step with registers");
`endif

endmodule
